// ===== sv/sawlc_pkg.sv =====
package sawlc_pkg;

	localparam int DefNumSets = 2;
	localparam int DefNumWays = 4;
	localparam int DefWordsPerLine = 2;

	localparam logic [1:0] OP_READ = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_FILL = 2'd2;
	localparam logic [1:0] OP_FLUSH = 2'd3;

	localparam logic [2:0] KIND_READ = 3'd0;
	localparam logic [2:0] KIND_WRITE = 3'd1;
	localparam logic [2:0] KIND_FETCH = 3'd2;
	localparam logic [2:0] KIND_WB = 3'd3;
	localparam logic [2:0] KIND_REJECT = 3'd4;

	// Request word layout, highest bit first
	typedef struct packed {
		logic [31:0] fill_word_high;
		logic [31:0] fill_word_low;
		logic [31:0] write_value;
		logic [31:0] address;
		logic [1:0]  op;
	} req_t;

endpackage

// ===== sv/sawlc_emit.sv =====
// Output register: queues a run of identical result words and drains them.
module sawlc_emit
	import sawlc_pkg::*;
#(
	parameter int CntW = 5
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  logic [2:0]      load_kind,
	input  logic [CntW-1:0] load_cnt,
	output logic            busy,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [7:0]      m_axis_tdata
);

	logic [CntW-1:0] cnt_q;
	logic [2:0]      kind_q;

	assign busy = (cnt_q != '0);
	assign m_axis_tvalid = busy;
	assign m_axis_tdata = {5'd0, kind_q};

	// Load a run, or count down as words are taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			kind_q <= KIND_READ;
		end else if (load) begin
			cnt_q <= load_cnt;
			kind_q <= load_kind;
		end else if (busy && m_axis_tready) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== sv/set_assoc_writeback_lru_cache.sv =====
// Set-associative write-back, write-allocate data cache with LRU replacement.
// Input channel s_axis_*: one request word per handshake (read, write, fill
// for the pending miss, flush). Output channel m_axis_*: result kinds, one per
// word: read data, write done, fetch request, writeback word, rejected.
// Each request is taken and the set's tags are read from the tag memory, then
// the set is evaluated and updated the next cycle. A fill is answered at once.
// A miss emits writeback words for a dirty victim, then one fetch request,
// and the block waits for a fill request.
// A flush walks every line and, for each dirty line, pauses while its
// writeback words drain.
// Results leave through a counting output register; a new request is taken
// only once the previous results have all been delivered, so a stalled
// receiver holds the block. Reset clears valid and dirty bits and sets each
// set's recency ranks to the way numbers; no clearing pass is needed.
// Line data and tags are undefined until written.
module set_assoc_writeback_lru_cache
	import sawlc_pkg::*;
#(
	parameter int NUM_SETS = DefNumSets,
	parameter int NUM_WAYS = DefNumWays,
	parameter int WORDS_PER_LINE = DefWordsPerLine
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// op[1:0], address[33:2], write_value[65:34], fill_word_low[97:66],
	// fill_word_high[129:98], zero pad
	input  logic [135:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// kind[2:0], zero pad
	output logic [7:0]   m_axis_tdata
);

	localparam int SetW  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WayW  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int WordW = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
	localparam int SetB  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 0;
	localparam int WayB  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 0;
	localparam int WordB = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 0;
	localparam int TagLo = 2 + WordB + SetB;
	localparam int TagW  = 32 - TagLo;
	localparam int LineW = (NUM_SETS * NUM_WAYS > 1) ? $clog2(NUM_SETS * NUM_WAYS) : 1;
	localparam int DataW = (NUM_SETS * NUM_WAYS * WORDS_PER_LINE > 1) ?
		$clog2(NUM_SETS * NUM_WAYS * WORDS_PER_LINE) : 1;
	localparam int CntW  = $clog2(WORDS_PER_LINE + 2) + 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EVAL  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	typedef logic [TagW-1:0] tag_t;
	typedef logic [WayW-1:0] rank_t;

	req_t req;
	assign req = req_t'(s_axis_tdata[129:0]);

	// Tag memory with one row per set, and a flat data memory
	tag_t        tag_mem [NUM_SETS][NUM_WAYS];
	logic [31:0] data_mem [NUM_SETS * NUM_WAYS * WORDS_PER_LINE];
	tag_t        tag_rd_s1 [NUM_WAYS];

	// Flag and rank state
	logic [NUM_WAYS-1:0] valid_q [NUM_SETS];
	logic [NUM_WAYS-1:0] dirty_q [NUM_SETS];
	rank_t               rank_q  [NUM_SETS][NUM_WAYS];

	logic [1:0]       state_q;
	logic             pend_q;
	logic             pend_wr_q;
	logic [31:0]      pend_addr_q;
	logic [31:0]      pend_val_q;
	logic [WayW-1:0]  pend_way_q;
	req_t             req_s1;
	logic [LineW-1:0] flush_idx_q;

	logic            emit_busy;
	logic            emit_load;
	logic [2:0]      emit_kind;
	logic [CntW-1:0] emit_cnt;

	sawlc_emit #(.CntW(CntW)) u_emit (
		.clk(clk), .arst_n(arst_n), .load(emit_load), .load_kind(emit_kind),
		.load_cnt(emit_cnt), .busy(emit_busy), .m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
	);

	// Fetch request pending behind the writeback words of a miss
	logic pre_wb_q;

	assign s_axis_tready = (state_q == ST_IDLE) && !emit_busy && !pre_wb_q;
	logic accept;
	assign accept = s_axis_tvalid && s_axis_tready;

	logic [SetW-1:0] in_set, ev_set, pend_set;
	always_comb begin
		in_set = '0;
		ev_set = '0;
		pend_set = '0;
		if (NUM_SETS > 1) begin
			in_set = SetW'(req.address >> (2 + WordB));
			ev_set = SetW'(req_s1.address >> (2 + WordB));
			pend_set = SetW'(pend_addr_q >> (2 + WordB));
		end
	end

	// Read the set's tags
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int w = 0; w < NUM_WAYS; w++) tag_rd_s1[w] <= tag_mem[in_set][w];
			req_s1 <= req;
		end
	end

	// Evaluate hit and victim
	logic            hit;
	logic [WayW-1:0] hit_way, pick;
	logic            any_free;
	logic [WayW-1:0] free_way, lru_way;
	always_comb begin
		hit = 1'b0;
		hit_way = '0;
		any_free = 1'b0;
		free_way = '0;
		lru_way = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (valid_q[ev_set][w] && tag_rd_s1[w] == tag_t'(req_s1.address >> TagLo)) begin
				hit = 1'b1;
				hit_way = WayW'(w);
			end
			if (!valid_q[ev_set][w]) begin
				any_free = 1'b1;
				free_way = WayW'(w);
			end
			if (rank_q[ev_set][w] == rank_t'(NUM_WAYS - 1)) lru_way = WayW'(w);
		end
		pick = any_free ? free_way : lru_way;
	end

	logic [WordW-1:0] ev_word, pend_word;
	always_comb begin
		ev_word = '0;
		pend_word = '0;
		if (WORDS_PER_LINE > 1) begin
			ev_word = WordW'(req_s1.address >> 2);
			pend_word = WordW'(pend_addr_q >> 2);
		end
	end

	// Touch a way: age younger ranks, make it most recent
	logic            touch_en;
	logic [SetW-1:0] touch_set;
	logic [WayW-1:0] touch_way;

	logic fill_go, ev_go, miss_dirty;
	assign fill_go = accept && req.op == OP_FILL && pend_q;
	assign ev_go = (state_q == ST_EVAL);
	assign miss_dirty = !hit && !any_free && dirty_q[ev_set][pick];

	always_comb begin
		touch_en = 1'b0;
		touch_set = ev_set;
		touch_way = hit_way;
		if (fill_go) begin
			touch_en = 1'b1;
			touch_set = pend_set;
			touch_way = pend_way_q;
		end else if (ev_go && !pend_q && hit && req_s1.op != OP_FLUSH) begin
			touch_en = 1'b1;
		end
	end

	logic flush_dirty;
	logic [SetW-1:0] fl_set;
	logic [WayW-1:0] fl_way;
	always_comb begin
		fl_set = '0;
		fl_way = '0;
		if (NUM_SETS > 1) fl_set = SetW'(flush_idx_q >> WayB);
		if (NUM_WAYS > 1) fl_way = WayW'(flush_idx_q);
		flush_dirty = dirty_q[fl_set][fl_way];
	end

	// Control, flags and ranks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q <= 1'b0;
			pend_wr_q <= 1'b0;
			pend_addr_q <= '0;
			pend_val_q <= '0;
			pend_way_q <= '0;
			pre_wb_q <= 1'b0;
			flush_idx_q <= '0;
			for (int s = 0; s < NUM_SETS; s++) begin
				valid_q[s] <= '0;
				dirty_q[s] <= '0;
				for (int w = 0; w < NUM_WAYS; w++) rank_q[s][w] <= rank_t'(w);
			end
		end else begin
			if (touch_en) begin
				for (int w = 0; w < NUM_WAYS; w++)
					if (rank_q[touch_set][w] < rank_q[touch_set][touch_way])
						rank_q[touch_set][w] <= rank_q[touch_set][w] + 1'b1;
				rank_q[touch_set][touch_way] <= '0;
			end
			if (pre_wb_q && !emit_busy) pre_wb_q <= 1'b0;
			if (fill_go) begin
				valid_q[pend_set][pend_way_q] <= 1'b1;
				dirty_q[pend_set][pend_way_q] <= pend_wr_q;
				pend_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && req.op != OP_FILL) begin
						if (!pend_q && req.op == OP_FLUSH) begin
							state_q <= ST_FLUSH;
							flush_idx_q <= '0;
						end else begin
							state_q <= ST_EVAL;
						end
					end
				end
				ST_EVAL: begin
					state_q <= ST_IDLE;
					if (!pend_q && !hit) begin
						valid_q[ev_set][pick] <= 1'b0;
						dirty_q[ev_set][pick] <= 1'b0;
						pend_q <= 1'b1;
						pend_wr_q <= (req_s1.op == OP_WRITE);
						pend_addr_q <= req_s1.address;
						pend_val_q <= req_s1.write_value;
						pend_way_q <= pick;
						pre_wb_q <= miss_dirty;
					end else if (!pend_q && req_s1.op == OP_WRITE) begin
						dirty_q[ev_set][hit_way] <= 1'b1;
					end
				end
				ST_FLUSH: begin
					if (!emit_busy) begin
						if (flush_idx_q == LineW'(NUM_SETS * NUM_WAYS - 1)) state_q <= ST_IDLE;
						else flush_idx_q <= flush_idx_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result loading
	always_comb begin
		emit_load = 1'b0;
		emit_kind = KIND_READ;
		emit_cnt = CntW'(1);
		if (fill_go) begin
			emit_load = 1'b1;
			emit_kind = pend_wr_q ? KIND_WRITE : KIND_READ;
		end else if (pre_wb_q && !emit_busy) begin
			emit_load = 1'b1;
			emit_kind = KIND_FETCH;
		end else if (ev_go) begin
			emit_load = 1'b1;
			if (pend_q) emit_kind = KIND_REJECT;
			else if (hit) emit_kind = (req_s1.op == OP_WRITE) ? KIND_WRITE : KIND_READ;
			else if (miss_dirty) begin
				emit_kind = KIND_WB;
				emit_cnt = CntW'(WORDS_PER_LINE);
			end else emit_kind = KIND_FETCH;
		end else if (state_q == ST_FLUSH && !emit_busy && flush_dirty) begin
			emit_load = 1'b1;
			emit_kind = KIND_WB;
			emit_cnt = CntW'(WORDS_PER_LINE);
		end
	end

	// Memory writes: fill line, store on write hit
	always_ff @(posedge clk) begin
		if (fill_go) begin
			tag_mem[pend_set][pend_way_q] <= tag_t'(pend_addr_q >> TagLo);
			for (int i = 0; i < WORDS_PER_LINE; i++)
				data_mem[DataW'(((int'(pend_set) * NUM_WAYS + int'(pend_way_q))
					* WORDS_PER_LINE) + i)]
					<= (pend_wr_q && i == int'(pend_word)) ? pend_val_q :
					   (i == 0) ? req.fill_word_low : (i == 1) ? req.fill_word_high : 32'd0;
		end else if (ev_go && !pend_q && hit && req_s1.op == OP_WRITE) begin
			data_mem[DataW'(((int'(ev_set) * NUM_WAYS + int'(hit_way)) * WORDS_PER_LINE)
				+ int'(ev_word))] <= req_s1.write_value;
		end
	end

endmodule

// ===== sv/sawlc_checker.sv =====
module sawlc_checker
	import sawlc_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [7:0]   m_axis_tdata
);

	// Kind codes stay in range
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2:0] <= KIND_REJECT)
		else $error("bad kind");

	// Padding stays zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[7:3] == 5'd0)
		else $error("pad set");

	// No new request while results wait
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("ready while busy");

	// Stalled output holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output dropped");

endmodule

bind set_assoc_writeback_lru_cache sawlc_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import sawlc_pkg::*;

	localparam int Sets = DefNumSets;
	localparam int Ways = DefNumWays;
	localparam int Wpl = DefWordsPerLine;
	localparam int Lines = Sets * Ways;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [135:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [7:0] m_axis_tdata;

	set_assoc_writeback_lru_cache dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// directed stimulus row; want_kind < 0 means the predictor alone sets the expectation
	typedef struct {
		logic [1:0] op;
		logic [31:0] address;
		logic [31:0] write_value;
		logic [31:0] fill_lo;
		logic [31:0] fill_hi;
		int want_kind;
	} row_t;

	// shadow cache state
	logic [27:0] tag_mem [Lines];
	logic valid_mem [Lines];
	logic dirty_mem [Lines];
	logic [1:0] rank_mem [Lines];
	logic miss_open;
	logic miss_write;
	logic [31:0] miss_addr;
	logic [1:0] miss_way;

	logic [2:0] kind_queue [$];
	int errors;
	bit src_idle_on;
	bit snk_idle_on;
	// addresses of recent lines, reused to get hits
	logic [31:0] hot_addr [$];

	function automatic int set_idx(logic [31:0] a);
		return int'(a[3]);
	endfunction

	function automatic logic [27:0] tag_bits(logic [31:0] a);
		return a[31:4];
	endfunction

	task automatic shadow_reset();
		for (int i = 0; i < Lines; i++) begin
			valid_mem[i] = 1'b0;
			dirty_mem[i] = 1'b0;
			rank_mem[i] = 2'(i % Ways);
		end
		miss_open = 1'b0;
		miss_write = 1'b0;
		miss_addr = '0;
		miss_way = '0;
	endtask

	task automatic make_recent(int s, int w);
		logic [1:0] r;
		r = rank_mem[s * Ways + w];
		for (int i = 0; i < Ways; i++)
			if (rank_mem[s * Ways + i] < r)
				rank_mem[s * Ways + i] = rank_mem[s * Ways + i] + 2'd1;
		rank_mem[s * Ways + w] = 2'd0;
	endtask

	task automatic push_writeback();
		for (int i = 0; i < Wpl; i++)
			kind_queue.push_back(KIND_WB);
	endtask

	// predict the result kinds of one request and update the shadow state
	task automatic predict_cache(logic [1:0] op, logic [31:0] a);
		int s;
		int pick;
		int base;
		if (op == OP_FILL) begin
			if (!miss_open)
				return;
			s = set_idx(miss_addr);
			tag_mem[s * Ways + miss_way] = tag_bits(miss_addr);
			valid_mem[s * Ways + miss_way] = 1'b1;
			dirty_mem[s * Ways + miss_way] = miss_write;
			make_recent(s, miss_way);
			miss_open = 1'b0;
			kind_queue.push_back(miss_write ? KIND_WRITE : KIND_READ);
			return;
		end
		if (miss_open) begin
			kind_queue.push_back(KIND_REJECT);
			return;
		end
		if (op == OP_FLUSH) begin
			for (int i = 0; i < Lines; i++)
				if (dirty_mem[i])
					push_writeback();
			return;
		end
		s = set_idx(a);
		base = s * Ways;
		for (int w = 0; w < Ways; w++) begin
			if (valid_mem[base + w] && tag_mem[base + w] == tag_bits(a)) begin
				make_recent(s, w);
				if (op == OP_WRITE) begin
					dirty_mem[base + w] = 1'b1;
					kind_queue.push_back(KIND_WRITE);
				end else begin
					kind_queue.push_back(KIND_READ);
				end
				return;
			end
		end
		pick = -1;
		for (int w = 0; w < Ways; w++)
			if (pick < 0 && !valid_mem[base + w])
				pick = w;
		if (pick < 0) begin
			pick = 0;
			for (int w = 1; w < Ways; w++)
				if (rank_mem[base + w] > rank_mem[base + pick])
					pick = w;
			if (dirty_mem[base + pick])
				push_writeback();
		end
		valid_mem[base + pick] = 1'b0;
		dirty_mem[base + pick] = 1'b0;
		miss_way = 2'(pick);
		miss_open = 1'b1;
		miss_write = (op == OP_WRITE);
		miss_addr = a;
		kind_queue.push_back(KIND_FETCH);
	endtask

	// send one word, with an occasional random gap before it
	task automatic send_word(logic [1:0] op, logic [31:0] a, logic [31:0] v,
			logic [31:0] f0, logic [31:0] f1, int want_kind);
		int depth;
		int got;
		if (src_idle_on && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 14)) @(negedge clk);
		depth = kind_queue.size();
		predict_cache(op, a);
		got = (kind_queue.size() > depth) ? int'(kind_queue[depth]) : -1;
		if (want_kind >= 0 && !(kind_queue.size() == depth + 1 && got == want_kind)) begin
			$display("%0t: directed row mismatch, expected kind %0d, actual predicted %0d",
				$time, want_kind, got);
			errors++;
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {6'd0, f1, f0, v, a, op};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic wait_drained();
		while (kind_queue.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [31:0] rand_addr();
		if (hot_addr.size() != 0 && $urandom_range(0, 2) != 0)
			return hot_addr[$urandom_range(0, hot_addr.size() - 1)]
				^ {29'd0, 1'b0, 2'($urandom)} ^ {29'd0, 1'($urandom), 2'd0};
		// few distinct tags so sets fill and evict
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return {26'd0, 3'($urandom_range(0, 5)), 3'($urandom)};
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: backpressure bursts and result check
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (snk_idle_on && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (kind_queue.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual kind %0d",
					$time, m_axis_tdata[2:0]);
				errors++;
			end else begin
				if (m_axis_tdata[2:0] !== kind_queue[0]) begin
					$display("%0t: kind mismatch, expected %0d, actual %0d",
						$time, kind_queue[0], m_axis_tdata[2:0]);
					errors++;
				end
				void'(kind_queue.pop_front());
			end
		end
	end

	// watchdog
	initial begin
		#20ms;
		$display("set_assoc_writeback_lru_cache regression: fail");
		$finish;
	end

	// stimulus
	initial begin
		row_t rows [$];
		logic [1:0] op;
		logic [31:0] a;
		int n;
		errors = 0;
		src_idle_on = 1'b1;
		snk_idle_on = 1'b1;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		shadow_reset();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: fill with nothing pending, cold misses, hits, reject,
		// eviction of a dirty LRU line, flush, extremes of every field
		rows = '{
			'{OP_FILL, 32'h0, 32'h0, 32'h0, 32'h0, -1},
			'{OP_FLUSH, 32'h0, 32'h0, 32'h0, 32'h0, -1},
			'{OP_READ, 32'h0, 32'h0, 32'h0, 32'h0, KIND_FETCH},
			'{OP_READ, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, KIND_REJECT},
			'{OP_WRITE, 32'h4, 32'h1, 32'h0, 32'h0, KIND_REJECT},
			'{OP_FLUSH, 32'h0, 32'h0, 32'h0, 32'h0, KIND_REJECT},
			'{OP_FILL, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, KIND_READ},
			'{OP_WRITE, 32'h4, 32'hFFFF_FFFF, 32'h0, 32'h0, KIND_WRITE},
			'{OP_READ, 32'h0, 32'h0, 32'h0, 32'h0, KIND_READ},
			'{OP_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, KIND_FETCH},
			'{OP_FILL, 32'h0, 32'h0, 32'h1234_5678, 32'h0, KIND_WRITE},
			'{OP_WRITE, 32'h10, 32'h5, 32'h0, 32'h0, -1},
			'{OP_FILL, 32'h0, 32'h0, 32'h0, 32'h0, -1},
			'{OP_WRITE, 32'h20, 32'h6, 32'h0, 32'h0, -1},
			'{OP_FILL, 32'h0, 32'h0, 32'h0, 32'h0, -1},
			'{OP_READ, 32'h30, 32'h0, 32'h0, 32'h0, -1},
			'{OP_FILL, 32'h0, 32'h0, 32'h0, 32'h0, -1},
			'{OP_READ, 32'h40, 32'h0, 32'h0, 32'h0, -1},
			'{OP_FILL, 32'h0, 32'h0, 32'h0, 32'h0, -1},
			'{OP_FLUSH, 32'h0, 32'h0, 32'h0, 32'h0, -1},
			'{OP_WRITE, 32'h18, 32'h7, 32'h0, 32'h0, -1},
			'{OP_FILL, 32'h0, 32'h0, 32'h0, 32'h0, -1},
			'{OP_FLUSH, 32'h0, 32'h0, 32'h0, 32'h0, -1}
		};
		foreach (rows[i])
			send_word(rows[i].op, rows[i].address, rows[i].write_value,
				rows[i].fill_lo, rows[i].fill_hi, rows[i].want_kind);

		// hold off until every result is back
		wait_drained();

		// random: mostly request then fill, with stray fills and rejects
		n = 0;
		while (n < 250) begin
			if (n >= 200) begin
				src_idle_on = 1'b0;
				snk_idle_on = 1'b0;
			end
			case ($urandom_range(0, 19))
				0: op = OP_FLUSH;
				1, 2: op = OP_FILL;
				default: op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
			endcase
			a = rand_addr();
			if (miss_open && op != OP_FILL && $urandom_range(0, 3) != 0)
				op = OP_FILL;
			if (op == OP_FILL && !miss_open) begin
				// stray fill, ignored by the block
				send_word(op, a, $urandom, $urandom, $urandom, -1);
				continue;
			end
			if (op != OP_FILL) begin
				hot_addr.push_back(a);
				if (hot_addr.size() > 12)
					void'(hot_addr.pop_front());
			end
			send_word(op, a, $urandom, $urandom, $urandom, -1);
			n++;
		end

		// drain, then let a flush walk finish
		wait_drained();
		repeat (40) @(negedge clk);
		if (errors == 0 && kind_queue.size() == 0) begin
			$display("set_assoc_writeback_lru_cache regression: pass");
		end else begin
			foreach (kind_queue[i])
				$display("%0t: missing word, expected kind %0d, actual none",
					$time, kind_queue[i]);
			$display("set_assoc_writeback_lru_cache regression: fail");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/sawlc_pkg.sv
sv/sawlc_emit.sv
sv/set_assoc_writeback_lru_cache.sv
sv/sawlc_checker.sv
tb/sv/testbench.sv
